FILE: sv/etps_pkg.sv
// Package for the event table priority select block: shared constants,
// command and status codes, and the controller-to-datapath command struct.
`timescale 1ns / 1ps
package etps_pkg;
	localparam int MaxEntries = 64;
	localparam int KindWidth  = 16;
	localparam int LineWidth  = 6;
	localparam int LevelsWidth = 64;
	localparam int KindPortWidth = 16;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_WAIT   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the input beat
		logic search;   // register the match vectors
		logic commit;   // update list and result
	} dp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic dummy_ok;
	} dp_stat_t;
endpackage

FILE: sv/event_table_priority_select.sv
// Top level of the event table priority select block.
// Depends on etps_pkg, etps_ctrl and etps_dp.
`timescale 1ns / 1ps
// The block keeps an ordered list of up to MAX_ENTRIES entries, each an event
// kind bound to an event line, held in register cells. An add beat appends an
// entry, a remove beat deletes the first entry of a kind and closes the gap,
// and a wait beat returns the kind of the first entry whose line is high,
// moving it to the back of the list when rotate_mode is set. Each input beat
// yields one result beat. The beat is captured at the edge that accepts it;
// the SEARCH state then registers the parallel match search and priority scan
// over all cells, and the COMMIT state shifts the cells and registers the
// result. The controller returns to IDLE before it takes the next beat, so a
// new beat is accepted only once the previous one has been committed. The
// result register lets the next beat enter while an earlier result still
// waits; that beat then holds in COMMIT until the waiting result is taken.
// Write rotate_mode only while the block is idle.
module event_table_priority_select #(
	parameter int MAX_ENTRIES = etps_pkg::MaxEntries,
	parameter int KIND_WIDTH  = etps_pkg::KindWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] kind,
	input  logic [5:0]  event_line,
	input  logic [63:0] event_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] selected_kind
);
	etps_pkg::dp_cmd_t dp_cmd;
	logic rotate_mode_q;

	// The configuration register is always writable.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			rotate_mode_q <= cfg_data;
		end
	end

	etps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd_o     (dp_cmd)
	);

	etps_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KIND_WIDTH  (KIND_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_i         (dp_cmd),
		.rotate_mode   (rotate_mode_q),
		.cmd           (cmd),
		.kind          (kind),
		.event_line    (event_line),
		.event_levels  (event_levels),
		.status        (status),
		.selected_kind (selected_kind)
	);
endmodule

FILE: sv/etps_ctrl.sv
// Controller state machine for the event table priority select block.
// Depends on etps_pkg for the command struct.
`timescale 1ns / 1ps
module etps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output etps_pkg::dp_cmd_t cmd_o
);
	typedef enum logic [3:0] {
		IDLE   = 4'b0001,
		SEARCH = 4'b0010,
		COMMIT = 4'b0100,
		OUTPUT = 4'b1000
	} state_t;

	state_t state_q;

	// The result register frees once taken; a new beat may enter while it waits.
	logic out_busy;
	assign out_busy = out_valid && !out_ready;
	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd_o.load   = in_valid && in_ready;
		cmd_o.search = (state_q == SEARCH);
		cmd_o.commit = (state_q == COMMIT) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				IDLE:    if (in_valid) state_q <= SEARCH;
				SEARCH:  state_q <= COMMIT;
				COMMIT: begin
					if (!out_busy) begin
						out_valid <= 1'b1;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

FILE: sv/etps_dp.sv
// Datapath for the event table priority select block: the entry list in
// register cells, the parallel match search and the compaction network.
`timescale 1ns / 1ps
module etps_dp #(
	parameter int MAX_ENTRIES = etps_pkg::MaxEntries,
	parameter int KIND_WIDTH  = etps_pkg::KindWidth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  etps_pkg::dp_cmd_t                    cmd_i,
	input  logic                                 rotate_mode,
	input  logic [1:0]                           cmd,
	input  logic [etps_pkg::KindPortWidth-1:0]   kind,
	input  logic [etps_pkg::LineWidth-1:0]       event_line,
	input  logic [etps_pkg::LevelsWidth-1:0]     event_levels,
	output logic [1:0]                           status,
	output logic [etps_pkg::KindPortWidth-1:0]   selected_kind
);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int LW = etps_pkg::LineWidth;

	logic [KIND_WIDTH-1:0] kinds_q [MAX_ENTRIES];
	logic [LW-1:0]         lines_q [MAX_ENTRIES];
	logic [CW-1:0]         count_q;

	logic [1:0]                        cmd_q;
	logic [KIND_WIDTH-1:0]             kind_q;
	logic [LW-1:0]                     line_q;
	logic [etps_pkg::LevelsWidth-1:0]  levels_q;

	// Per-entry hit flags, then a prefix "hit at or before" vector, registered.
	logic [MAX_ENTRIES-1:0] hit, first_s1, after_s1;
	logic                   any_s1;
	logic [MAX_ENTRIES-1:0] seen;

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit[i] = (CW'(i) < count_q) && ((cmd_q == etps_pkg::CMD_REMOVE)
				? (kinds_q[i] == kind_q) : levels_q[lines_q[i]]);
		end
		// Prefix OR as a log-depth scan.
		seen = hit;
		for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
			seen = seen | (seen << s);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q    <= cmd;
			kind_q   <= kind[KIND_WIDTH-1:0];
			line_q   <= event_line;
			levels_q <= event_levels;
		end
		if (cmd_i.search) begin
			first_s1 <= hit & ~(seen << 1);
			after_s1 <= seen;
			any_s1   <= |hit;
		end
	end

	// Selected entry fields by one-hot OR.
	logic [KIND_WIDTH-1:0] sel_kind;
	logic [LW-1:0]         sel_line;
	always_comb begin
		sel_kind = '0;
		sel_line = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (first_s1[i]) begin
				sel_kind = sel_kind | kinds_q[i];
				sel_line = sel_line | lines_q[i];
			end
		end
	end

	logic do_drop, do_rot, do_add;
	logic [1:0] st_n;
	always_comb begin
		do_drop = 1'b0;
		do_rot  = 1'b0;
		do_add  = 1'b0;
		st_n    = etps_pkg::ST_ERR;
		case (cmd_q)
			etps_pkg::CMD_ADD: begin
				if (count_q < CW'(MAX_ENTRIES)) begin
					do_add = 1'b1;
					st_n   = etps_pkg::ST_OK;
				end
			end
			etps_pkg::CMD_REMOVE: begin
				if (any_s1) begin
					do_drop = 1'b1;
					st_n    = etps_pkg::ST_OK;
				end
			end
			etps_pkg::CMD_WAIT: begin
				if (count_q != '0) begin
					st_n = any_s1 ? etps_pkg::ST_OK : etps_pkg::ST_NONE;
					do_rot = any_s1 && rotate_mode;
				end
			end
			default: st_n = etps_pkg::ST_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_i.commit) begin
			if (do_add) count_q <= count_q + CW'(1);
			else if (do_drop) count_q <= count_q - CW'(1);
		end
	end

	// Each cell at or behind the hit takes its neighbor; the last live cell
	// takes the served entry when rotating.
	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			status        <= st_n;
			selected_kind <= (cmd_q == etps_pkg::CMD_WAIT && any_s1)
				? etps_pkg::KindPortWidth'(sel_kind) : '0;
			if (do_add) begin
				kinds_q[count_q[IW-1:0]] <= kind_q;
				lines_q[count_q[IW-1:0]] <= line_q;
			end
			if (do_drop || do_rot) begin
				for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
					if (after_s1[i] && CW'(i + 1) < count_q) begin
						kinds_q[i] <= kinds_q[i + 1];
						lines_q[i] <= lines_q[i + 1];
					end
				end
			end
			if (do_rot) begin
				kinds_q[IW'(count_q - CW'(1))] <= sel_kind;
				lines_q[IW'(count_q - CW'(1))] <= sel_line;
			end
		end
	end
endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for event_table_priority_select.
// Depends on etps_pkg and the event_table_priority_select RTL; predicts each
// result from a model of the ordered event list kept in the bench.
`timescale 1ns / 1ps
module tb_top;
	localparam int LatencyCycles = 3;
	localparam int RandomItems = 1500;
	localparam logic [1:0] CmdUnused = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] selected_kind;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [15:0] kind = '0;
	logic [5:0]  event_line = '0;
	logic [63:0] event_levels = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] selected_kind;

	// The bench's own copy of the list. Only the first list_len entries
	// hold meaning, exactly as in the block.
	logic [15:0] list_kinds[etps_pkg::MaxEntries];
	logic [5:0]  list_lines[etps_pkg::MaxEntries];
	int          list_len = 0;
	logic        rotate_on = 1'b0;

	verdict_t    pending_verdicts[$];
	int          error_count = 0;
	bit          hold_off = 1'b0;
	bit          rx_calm = 1'b0;

	event_table_priority_select dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .kind(kind),
		.event_line(event_line), .event_levels(event_levels),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .selected_kind(selected_kind)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAIL event_table_priority_select");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		error_count++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Remove entry pos and pull the entries behind it up one place.
	function automatic void close_gap(input int pos);
		for (int i = pos; i + 1 < list_len; i++) begin
			list_kinds[i] = list_kinds[i + 1];
			list_lines[i] = list_lines[i + 1];
		end
		list_len--;
	endfunction

	// Apply one command to the list and return the result it should give.
	function automatic verdict_t apply_command(input logic [1:0] c, input logic [15:0] k,
			input logic [5:0] ln, input logic [63:0] lv);
		verdict_t v;
		logic [15:0] hit_kind;
		logic [5:0]  hit_line;
		v.status = etps_pkg::ST_ERR;
		v.selected_kind = '0;
		if (c == etps_pkg::CMD_ADD) begin
			if (list_len < etps_pkg::MaxEntries) begin
				list_kinds[list_len] = k;
				list_lines[list_len] = ln;
				list_len++;
				v.status = etps_pkg::ST_OK;
			end
		end else if (c == etps_pkg::CMD_REMOVE) begin
			for (int i = 0; i < list_len; i++) begin
				if (list_kinds[i] == k) begin
					close_gap(i);
					v.status = etps_pkg::ST_OK;
					break;
				end
			end
		end else if (c == etps_pkg::CMD_WAIT && list_len != 0) begin
			v.status = etps_pkg::ST_NONE;
			for (int i = 0; i < list_len; i++) begin
				if (lv[list_lines[i]]) begin
					hit_kind = list_kinds[i];
					hit_line = list_lines[i];
					v.status = etps_pkg::ST_OK;
					v.selected_kind = hit_kind;
					if (rotate_on) begin
						close_gap(i);
						list_kinds[list_len] = hit_kind;
						list_lines[list_len] = hit_line;
						list_len++;
					end
					break;
				end
			end
		end
		return v;
	endfunction

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one beat and hold it until the block takes it. Valid drops only
	// when a gap follows, so back-to-back beats keep it high.
	task automatic send_beat(input logic [1:0] c, input logic [15:0] k,
			input logic [5:0] ln, input logic [63:0] lv, input bit gaps);
		int gap;
		gap = gaps ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		kind <= k;
		event_line <= ln;
		event_levels <= lv;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_verdicts.push_back(apply_command(c, k, ln, lv));
		@(negedge clk);
	endtask

	// Every result check runs here: each result beat against the oldest expectation.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report("unexpected result beat", status, -1);
			end else begin
				want = pending_verdicts.pop_front();
				if (status !== want.status)
					report("status", status, want.status);
				if (selected_kind !== want.selected_kind)
					report("selected_kind", selected_kind, want.selected_kind);
			end
		end
	end

	// Receiver: random stalls, a calm stretch, and a forced long hold-off.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (rx_calm) begin
				out_ready <= 1'b1;
			end else begin
				stall = pick_gap();
				out_ready <= (stall == 0);
			end
		end
	end

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0 && guard < 100_000) begin
			@(negedge clk);
			guard++;
		end
		if (pending_verdicts.size() != 0) begin
			$display("FAIL event_table_priority_select");
			$finish;
		end
		repeat (LatencyCycles + 4) @(negedge clk);
	endtask

	// Write rotate_mode while the block has nothing in flight.
	task automatic set_rotate(input logic on);
		drain();
		cfg_data <= on;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		rotate_on = on;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] random_levels();
		return {$urandom(), $urandom()};
	endfunction

	// Directed: extremes, every command, and each corner of the list.
	task automatic test_directed();
		send_beat(etps_pkg::CMD_WAIT, 16'hffff, 6'd0, '1, 1'b0);   // wait on empty list
		send_beat(etps_pkg::CMD_REMOVE, 16'h0000, 6'd0, '0, 1'b0); // remove from empty list
		send_beat(CmdUnused, 16'hffff, 6'd63, '1, 1'b0);           // unused command code
		send_beat(etps_pkg::CMD_ADD, 16'h0000, 6'd0, '0, 1'b0);
		send_beat(etps_pkg::CMD_ADD, 16'hffff, 6'd63, '0, 1'b0);
		send_beat(etps_pkg::CMD_ADD, 16'h5a5a, 6'd21, '0, 1'b0);
		send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, '0, 1'b0);      // nothing signaled
		send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, 64'h8000_0000_0000_0000, 1'b0);
		send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, '1, 1'b0);
		send_beat(etps_pkg::CMD_REMOVE, 16'h1234, 6'd0, '0, 1'b0); // kind not present
		send_beat(etps_pkg::CMD_REMOVE, 16'hffff, 6'd0, '0, 1'b0); // remove from the middle
		send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, 64'h0000_0000_0020_0000, 1'b0);
		send_beat(etps_pkg::CMD_REMOVE, 16'h0000, 6'd0, '0, 1'b0);
		send_beat(etps_pkg::CMD_REMOVE, 16'h5a5a, 6'd0, '0, 1'b0);
	endtask

	// Fill the list to the top, overflow it, and serve, rotating when rotate_mode is set.
	task automatic test_full_list();
		for (int i = 0; i < etps_pkg::MaxEntries; i++)
			send_beat(etps_pkg::CMD_ADD, 16'(i % 7), 6'(i), '0, 1'b1);
		send_beat(etps_pkg::CMD_ADD, 16'hbeef, 6'd1, '0, 1'b0);    // add to full list
		// On the first pass the served entry is already last.
		send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, 64'h8000_0000_0000_0000, 1'b0);
		send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, '1, 1'b0);
		for (int i = 0; i < 20; i++)
			send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, random_levels(), 1'b1);
	endtask

	// Keep the sink stalled while beats keep coming, so the input stalls too.
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_beat(etps_pkg::CMD_WAIT, 16'h0, 6'd0, random_levels(), 1'b0);
		join
	endtask

	// Random traffic over a small kind pool so hits are frequent.
	task automatic test_random(input int count);
		int r;
		logic [1:0]  c;
		logic [15:0] k;
		logic [5:0]  ln;
		logic [63:0] lv;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 38) c = etps_pkg::CMD_ADD;
			else if (r < 60) c = etps_pkg::CMD_REMOVE;
			else if (r < 98) c = etps_pkg::CMD_WAIT;
			else c = CmdUnused;
			k = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 15));
			ln = 6'($urandom());
			case ($urandom_range(0, 3))
				0: lv = random_levels();
				1: lv = 64'd1 << $urandom_range(0, 63);
				2: lv = random_levels() & random_levels() & random_levels();
				default: lv = $urandom_range(0, 1) ? '1 : '0;
			endcase
			rx_calm = (n % 400) < 40;
			send_beat(c, k, ln, lv, !rx_calm);
		end
		rx_calm = 1'b0;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		set_rotate(1'b1);
		test_directed();
		test_full_list();
		test_backpressure();
		set_rotate(1'b0);
		test_full_list();
		test_random(RandomItems / 2);
		set_rotate(1'b1);
		test_random(RandomItems / 2);
		set_rotate(1'b0);
		drain();
		if (error_count == 0)
			$display("PASS event_table_priority_select");
		else
			$display("FAIL event_table_priority_select");
		$finish;
	end
endmodule

FILE: event_table_priority_select.f
sv/etps_pkg.sv
sv/etps_ctrl.sv
sv/etps_dp.sv
sv/event_table_priority_select.sv
dv/tb_top.sv
